// ===== rtl/pcm_decimate_to_8bit_stereo_unit_assert.svh =====
// Assertion macros for the PCM decimator block.
// Used by the top level only; no other dependencies.
`ifndef PCM_DECIMATE_TO_8BIT_STEREO_UNIT_ASSERT_SVH
`define PCM_DECIMATE_TO_8BIT_STEREO_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCMD8_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCMD8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pcmd8_pkg.sv =====
// Shared types, constants and sample conversion for the PCM decimator.
// No dependencies.
`timescale 1ns / 1ps

package pcmd8_pkg;

  localparam int RATE_W    = 18;
  localparam int PHASE_W   = 19;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = 2'd2;

  typedef struct packed {
    logic              stereo_mode;
    logic [RATE_W-1:0] input_rate;
    logic [RATE_W-1:0] output_rate;
  } cfg_t;

  // Divide by 256 with truncation toward zero.
  function automatic logic signed [OUT_W-1:0] to_8bit(input logic signed [IN_W-1:0] s);
    logic signed [OUT_W-1:0] q;
    q = s[IN_W-1:IN_W-OUT_W];
    if (s[IN_W-1] && (s[IN_W-OUT_W-1:0] != '0)) begin
      q = q + OUT_W'(1);
    end
    return q;
  endfunction

endpackage

// ===== rtl/pcmd8_phase.sv =====
// Phase accumulator that picks which frames survive decimation.
// Depends on pcmd8_pkg for the configuration struct and widths.
`timescale 1ns / 1ps

module pcmd8_phase (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcmd8_pkg::cfg_t              cfg,
  input  logic                         advance,
  input  logic                         buffer_end,
  output logic                         emit,
  output logic                         decimating,
  output logic [pcmd8_pkg::PHASE_W-1:0] phase
);

  logic [pcmd8_pkg::PHASE_W-1:0] phase_r;
  logic [pcmd8_pkg::PHASE_W-1:0] phase_nxt;
  logic [pcmd8_pkg::PHASE_W-1:0] in_rate_ext;
  logic [pcmd8_pkg::PHASE_W-1:0] out_rate_ext;
  logic [pcmd8_pkg::PHASE_W-1:0] step;

  assign in_rate_ext  = {1'b0, cfg.input_rate};
  assign out_rate_ext = {1'b0, cfg.output_rate};
  assign decimating   = cfg.input_rate > cfg.output_rate;
  assign emit         = decimating ? (phase_r < out_rate_ext) : 1'b1;
  assign step         = emit ? in_rate_ext : '0;
  assign phase        = phase_r;

  always_comb begin
    phase_nxt = phase_r;
    if (advance) begin
      if (buffer_end || !decimating) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_r + step - out_rate_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/pcm_decimate_to_8bit_stereo_unit.sv =====
// Top level of the 16-bit to 8-bit stereo PCM decimator.
// Depends on pcmd8_pkg, pcmd8_phase and the assertion macro header.
//
// Usage: frames enter on the in_ channel (left, right, buffer_end) under
// valid/ready. A frame is either dropped by the phase accumulator or turned
// into one 8-bit stereo result on the out_ channel. Mono frames copy the
// left result onto the right output.
// Registers are written on the cfg_ channel (index 0 stereo_mode, 1
// input_rate, 2 output_rate); cfg_ready is always high, and writes are
// expected only while no frame is in flight.
// A kept frame's result is registered in the output slot, or in the skid
// register while the output stalls. Throughput is one frame per cycle while
// in_ready is high, as the phase compare and add are combinational. Once the
// skid register holds a result, in_ready drops until the output drains.
// Reset clears the phase remainder and both output slots and restores the
// registers to stereo mode with both rates at 44100 Hz.
`timescale 1ns / 1ps
`include "pcm_decimate_to_8bit_stereo_unit_assert.svh"

module pcm_decimate_to_8bit_stereo_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pcmd8_pkg::IN_W-1:0]     in_left_sample,
  input  logic signed [pcmd8_pkg::IN_W-1:0]     in_right_sample,
  input  logic                                  in_buffer_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pcmd8_pkg::OUT_W-1:0]    out_left_out,
  output logic signed [pcmd8_pkg::OUT_W-1:0]    out_right_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pcmd8_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcmd8_pkg::RATE_W-1:0]          cfg_data
);

  pcmd8_pkg::cfg_t cfg_r;
  logic            accept;
  logic            emit;
  logic            decimating;
  logic            new_valid;
  logic            drain;
  logic [pcmd8_pkg::PHASE_W-1:0] phase;

  logic signed [pcmd8_pkg::OUT_W-1:0] new_left;
  logic signed [pcmd8_pkg::OUT_W-1:0] new_right;

  logic                               out_valid_r;
  logic signed [pcmd8_pkg::OUT_W-1:0] out_left_r;
  logic signed [pcmd8_pkg::OUT_W-1:0] out_right_r;
  logic                               skid_valid_r;
  logic signed [pcmd8_pkg::OUT_W-1:0] skid_left_r;
  logic signed [pcmd8_pkg::OUT_W-1:0] skid_right_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign drain     = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stereo_mode <= 1'b1;
      cfg_r.input_rate  <= pcmd8_pkg::RATE_RESET;
      cfg_r.output_rate <= pcmd8_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcmd8_pkg::REG_STEREO_MODE: cfg_r.stereo_mode <= cfg_data[0];
        pcmd8_pkg::REG_INPUT_RATE:  cfg_r.input_rate  <= cfg_data;
        pcmd8_pkg::REG_OUTPUT_RATE: cfg_r.output_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  pcmd8_phase u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .advance    (accept),
    .buffer_end (in_buffer_end),
    .emit       (emit),
    .decimating (decimating),
    .phase      (phase)
  );

  assign new_valid = accept && emit;
  assign new_left  = pcmd8_pkg::to_8bit(in_left_sample);
  assign new_right = cfg_r.stereo_mode ? pcmd8_pkg::to_8bit(in_right_sample) : new_left;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || drain) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= new_valid;
        end else begin
          out_valid_r <= new_valid;
        end
      end else if (new_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || drain) begin
      if (skid_valid_r) begin
        out_left_r  <= skid_left_r;
        out_right_r <= skid_right_r;
        if (new_valid) begin
          skid_left_r  <= new_left;
          skid_right_r <= new_right;
        end
      end else if (new_valid) begin
        out_left_r  <= new_left;
        out_right_r <= new_right;
      end
    end else if (new_valid) begin
      skid_left_r  <= new_left;
      skid_right_r <= new_right;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  `PCMD8_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r,
    "skid register holds an item while the output slot is empty")
  `PCMD8_ASSERT_NEXT(a_buffer_end_clears, clk, rst_n, accept && in_buffer_end, phase == '0,
    "phase remainder not cleared after a buffer end")
  `PCMD8_ASSERT_NEXT(a_passthrough_zero, clk, rst_n, accept && !decimating, phase == '0,
    "phase remainder not held at zero in pass-through")
  `PCMD8_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid_r && !out_ready, out_valid_r,
    "pending result lost while the receiver stalls")

endmodule

// ===== dv/tb_pcm_decimate_to_8bit_stereo_unit.sv =====
// Testbench for pcm_decimate_to_8bit_stereo_unit: directed and random PCM frames under
// several rate settings, checked against a phase-accumulator predictor in a scoreboard class.
// Depends on pcmd8_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_pcm_decimate_to_8bit_stereo_unit;

  localparam logic [pcmd8_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic signed [pcmd8_pkg::IN_W-1:0] sample_t;
  typedef logic [pcmd8_pkg::RATE_W-1:0]      rate_word_t;

  typedef struct packed {
    logic signed [pcmd8_pkg::OUT_W-1:0] left;
    logic signed [pcmd8_pkg::OUT_W-1:0] right;
  } pcm8_pair_t;

  class decimation_scoreboard;
    pcmd8_pkg::cfg_t               regs;
    logic [pcmd8_pkg::PHASE_W-1:0] phase;
    pcm8_pair_t                    pending[$];
    int                            frames;
    int                            results;
    int                            buffer_ends;
    int                            mismatches;

    function new();
      regs.stereo_mode = 1'b1;
      regs.input_rate  = pcmd8_pkg::RATE_RESET;
      regs.output_rate = pcmd8_pkg::RATE_RESET;
      phase       = '0;
      frames      = 0;
      results     = 0;
      buffer_ends = 0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [pcmd8_pkg::CFG_IDX_W-1:0] idx,
                            logic [pcmd8_pkg::RATE_W-1:0] data);
      case (idx)
        pcmd8_pkg::REG_STEREO_MODE: regs.stereo_mode = data[0];
        pcmd8_pkg::REG_INPUT_RATE:  regs.input_rate  = data;
        pcmd8_pkg::REG_OUTPUT_RATE: regs.output_rate = data;
        default: ;
      endcase
    endfunction

    function logic signed [pcmd8_pkg::OUT_W-1:0] shrink(logic signed [pcmd8_pkg::IN_W-1:0] s);
      int v;
      v = int'(s);
      v = v / 256;
      return v[pcmd8_pkg::OUT_W-1:0];
    endfunction

    function void note_frame(logic signed [pcmd8_pkg::IN_W-1:0] l,
                             logic signed [pcmd8_pkg::IN_W-1:0] r, logic last);
      logic [31:0] acc;
      bit          keep;
      pcm8_pair_t  p;
      frames++;
      if (regs.input_rate > regs.output_rate) begin
        acc  = {13'b0, phase};
        keep = acc < regs.output_rate;
        if (keep) begin
          acc = acc + regs.input_rate;
        end
        acc   = acc - regs.output_rate;
        phase = acc[pcmd8_pkg::PHASE_W-1:0];
      end else begin
        keep  = 1'b1;
        phase = '0;
      end
      if (last) begin
        phase = '0;
        buffer_ends++;
      end
      if (keep) begin
        p.left  = shrink(l);
        p.right = regs.stereo_mode ? shrink(r) : p.left;
        pending.push_back(p);
      end
    endfunction

    function void check_result(logic signed [pcmd8_pkg::OUT_W-1:0] l,
                               logic signed [pcmd8_pkg::OUT_W-1:0] r);
      pcm8_pair_t want;
      results++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected item %0d: left %0d right %0d", results, l, r);
        end
        return;
      end
      want = pending.pop_front();
      if (l !== want.left || r !== want.right) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("item %0d: expected left %0d right %0d, got left %0d right %0d",
                   results, want.left, want.right, l, r);
        end
      end
    endfunction
  endclass

  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_ready;
  logic signed [pcmd8_pkg::IN_W-1:0]     in_left_sample;
  logic signed [pcmd8_pkg::IN_W-1:0]     in_right_sample;
  logic                                  in_buffer_end;
  logic                                  out_valid;
  logic                                  out_ready;
  logic signed [pcmd8_pkg::OUT_W-1:0]    out_left_out;
  logic signed [pcmd8_pkg::OUT_W-1:0]    out_right_out;
  logic                                  cfg_valid;
  logic                                  cfg_ready;
  logic [pcmd8_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [pcmd8_pkg::RATE_W-1:0]          cfg_data;

  decimation_scoreboard board;
  int gap_pct;
  int stall_pct;
  int settings;

  pcm_decimate_to_8bit_stereo_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_buffer_end   (in_buffer_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        board.write_reg(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        board.note_frame(in_left_sample, in_right_sample, in_buffer_end);
      end
      if (out_valid && out_ready) begin
        board.check_result(out_left_out, out_right_out);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_frame(logic signed [pcmd8_pkg::IN_W-1:0] l,
                            logic signed [pcmd8_pkg::IN_W-1:0] r, logic last);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_left_sample  <= l;
    in_right_sample <= r;
    in_buffer_end   <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic put_reg(logic [pcmd8_pkg::CFG_IDX_W-1:0] idx,
                         logic [pcmd8_pkg::RATE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(logic mode, logic [pcmd8_pkg::RATE_W-1:0] fin,
                               logic [pcmd8_pkg::RATE_W-1:0] fout);
    logic [pcmd8_pkg::RATE_W-1:0] mode_word;
    mode_word    = rate_word_t'($urandom);
    mode_word[0] = mode;
    wait_idle();
    put_reg(pcmd8_pkg::REG_STEREO_MODE, mode_word);
    put_reg(pcmd8_pkg::REG_INPUT_RATE, fin);
    put_reg(pcmd8_pkg::REG_OUTPUT_RATE, fout);
    if ($urandom_range(0, 3) == 0) begin
      put_reg(REG_UNUSED, rate_word_t'($urandom));
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic signed [pcmd8_pkg::IN_W-1:0] pick_sample();
    logic signed [pcmd8_pkg::IN_W-1:0] s;
    s = sample_t'($urandom);
    case ($urandom_range(0, 3))
      0: s[7:0] = 8'h00;
      1: s[7:0] = 8'h01;
      2: s[7:0] = 8'hFF;
      default: ;
    endcase
    if ($urandom_range(0, 15) == 0) begin
      s = {s[pcmd8_pkg::IN_W-1], {(pcmd8_pkg::IN_W-1){~s[pcmd8_pkg::IN_W-1]}}};
    end
    return s;
  endfunction

  task automatic run_frames(int count);
    int   left_in_buffer;
    logic last;
    left_in_buffer = $urandom_range(1, 40);
    for (int i = 0; i < count; i++) begin
      left_in_buffer--;
      last = (left_in_buffer == 0);
      if (last) begin
        left_in_buffer = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      end else if ($urandom_range(0, 49) == 0) begin
        last = 1'b1;
      end
      send_frame(pick_sample(), pick_sample(), last);
    end
  endtask

  initial begin
    board           = new();
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_left_sample  = '0;
    in_right_sample = '0;
    in_buffer_end   = 1'b0;
    out_ready       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = pcmd8_pkg::REG_STEREO_MODE;
    cfg_data        = '0;
    gap_pct         = 0;
    stall_pct       = 0;
    settings        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: stereo, equal rates, so every frame passes.
    send_frame(32767, -32768, 1'b0);
    send_frame(-1, 1, 1'b0);
    send_frame(-256, 256, 1'b0);
    send_frame(-255, 255, 1'b0);
    send_frame(-257, 257, 1'b1);
    send_frame(-32512, 32512, 1'b0);

    apply_setting(1'b0, 18'd48000, 18'd32000);
    send_frame(-32768, 5, 1'b0);
    send_frame(32767, -7, 1'b0);
    send_frame(-129, 300, 1'b0);
    send_frame(1000, -1000, 1'b1);
    send_frame(-513, 12, 1'b0);
    send_frame(767, -3, 1'b0);

    apply_setting(1'b1, 18'h3FFFF, 18'd0);
    send_frame(12345, -12345, 1'b0);
    send_frame(-32768, 32767, 1'b1);
    send_frame(256, -256, 1'b0);

    apply_setting(1'b1, 18'd8000, 18'd192000);
    send_frame(-32768, -32768, 1'b0);
    send_frame(32767, 32767, 1'b0);
    send_frame(-1, -255, 1'b1);

    apply_setting(1'b0, 18'h3FFFF, 18'h3FFFE);
    send_frame(-300, 1, 1'b0);
    send_frame(511, 2, 1'b0);
    send_frame(-32767, 3, 1'b1);
    send_frame(4096, 4, 1'b0);

    for (int k = 0; k < 14; k++) begin
      case (k)
        0:  apply_setting(1'b1, 18'd48000, 18'd44100);
        1:  apply_setting(1'b0, 18'd192000, 18'd8000);
        2:  apply_setting(1'b1, 18'd96000, 18'd48000);
        3:  apply_setting(1'b0, 18'd8000, 18'd192000);
        4:  apply_setting(1'b1, 18'd44100, 18'd32000);
        5:  apply_setting(1'b0, 18'h3FFFF, 18'h20000);
        6:  apply_setting(1'b1, 18'd192000, 18'd191999);
        7:  apply_setting(1'b1, 18'd0, 18'd0);
        8:  apply_setting(1'b0, 18'h3FFFF, 18'd0);
        9:  apply_setting(1'b1, 18'h3FFFF, 18'd1);
        13: apply_setting(1'b1, 18'd44100, 18'd22050);
        default: apply_setting(1'($urandom_range(0, 1)),
                               rate_word_t'($urandom_range(8000, 192000)),
                               rate_word_t'($urandom_range(8000, 192000)));
      endcase
      if (k == 13 || k % 3 == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(5, 30);
        stall_pct = $urandom_range(5, 30);
      end
      run_frames(135);
    end

    wait_idle();
    repeat (20) @(negedge clk);
    $display("Ran %0d frames with %0d buffer ends over %0d register settings.",
             board.frames, board.buffer_ends, settings);
    $display("Checked %0d results; %0d mismatches, %0d results never arrived.",
             board.results, board.mismatches, board.pending.size());
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb_pcm_decimate_to_8bit_stereo_unit OK");
    end else begin
      $display("tb_pcm_decimate_to_8bit_stereo_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected.", board.pending.size());
    $display("tb_pcm_decimate_to_8bit_stereo_unit NOT OK");
    $finish;
  end

endmodule
